// File: rtl/core/mfp_pkg.sv
// Shared types and constants of the media frame packetizer.
package mfp_pkg;

	// controller states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CHK  = 2'd1;
	localparam logic [1:0] ST_HDR  = 2'd2;
	localparam logic [1:0] ST_PAY  = 2'd3;

	// configuration register indexes
	localparam logic [3:0] REG_MAGIC    = 4'd0;
	localparam logic [3:0] REG_VERSION  = 4'd1;
	localparam logic [3:0] REG_VID_TYPE = 4'd2;
	localparam logic [3:0] REG_AUD_TYPE = 4'd3;
	localparam logic [3:0] REG_COM_FLAG = 4'd4;
	localparam logic [3:0] REG_FRG_FLAG = 4'd5;
	localparam logic [3:0] REG_ABS_FLAG = 4'd6;
	localparam logic [3:0] REG_FRG_LIM  = 4'd7;

	// extension length codes and the common extension tag
	localparam logic [7:0] EXT_SINGLE = 8'd14;
	localparam logic [7:0] EXT_FIRST  = 8'd20;
	localparam logic [7:0] EXT_LATER  = 8'd6;
	localparam logic [7:0] COMMON_TAG = 8'd10;

	// header byte positions in the full layout
	localparam logic [5:0] POS_FIXED_END = 6'd19;
	localparam logic [5:0] POS_FRAG      = 6'd20;
	localparam logic [5:0] POS_FRAG_END  = 6'd25;
	localparam logic [5:0] POS_COMMON    = 6'd26;
	localparam logic [5:0] POS_END       = 6'd39;

	localparam logic [5:0] DIV_STEPS = 6'd33;

	typedef struct packed {
		logic accept;
		logic hdr_begin;
		logic hdr_emit;
		logic hdr_done;
		logic hdr_flags;
		logic pay_emit;
		logic skip;
	} mfp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic start;
		logic rem_zero;
		logic bif_zero;
		logic idx_ge_tot;
		logic hdr_last;
		logic out_free;
	} mfp_sts_t;

endpackage

// File: rtl/core/mfp_datapath.sv
// Datapath: config registers, message state, fragment count divider, byte mux, output register.
module mfp_datapath import mfp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [3:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic [7:0]         data_byte,
	input  logic               message_start,
	input  logic               media_kind,
	input  logic [7:0]         codec_code,
	input  logic [7:0]         kind_detail,
	input  logic [7:0]         channel_count,
	input  logic signed [63:0] timestamp_ms,
	input  logic signed [63:0] abs_time_ms,
	input  logic [15:0]        frame_number,
	input  logic [31:0]        message_length,
	input  mfp_cmd_t           cmd,
	output mfp_sts_t           sts,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               frame_end,
	output logic               run_last
);

	logic [15:0] magic_q;
	logic [7:0]  version_q, vid_type_q, aud_type_q, com_flag_q, frg_flag_q, abs_flag_q;
	logic [15:0] frg_lim_q;

	logic [63:0] ts_q, abs_q;
	logic [23:0] media_q;
	logic        kind_q;
	logic [15:0] fnum_q;
	logic [7:0]  data_q;

	logic        start_q, frag_q;
	logic [31:0] rem_q, chunk_q;
	logic [15:0] total_q, index_q, bif_q;
	logic [5:0]  pos_q;

	logic [32:0] num_q;
	logic [15:0] dr_q, div_lim_q;
	logic [5:0]  div_cnt_q;

	logic        out_valid_q, frame_end_q, run_last_q;
	logic [7:0]  out_byte_q;

	logic [15:0] lim_eff;
	logic [32:0] numer;
	logic [16:0] trial;
	logic        ge;
	logic [15:0] dr_n;
	logic [32:0] num_n;
	logic        first, with_common, out_free, load;
	logic [31:0] chunk_n;
	logic [7:0]  hdr_byte, flags, ext;
	logic [5:0]  pos_n;
	logic [63:0] ts_sh, abs_sh;
	logic [31:0] chunk_sh;
	logic [23:0] media_sh;
	logic [5:0]  abs_off, media_off;
	logic [3:0]  ts_off;
	logic [1:0]  chunk_off;

	assign lim_eff = (frg_lim_q == 16'd0) ? 16'd1 : frg_lim_q;
	assign numer   = {1'b0, message_length} + {17'd0, lim_eff} - 33'd1;

	// restoring divider, one quotient bit a cycle
	assign trial = {dr_q, num_q[32]};
	assign ge    = trial >= {1'b0, div_lim_q};
	assign dr_n  = ge ? 16'(trial - {1'b0, div_lim_q}) : trial[15:0];
	assign num_n = {num_q[31:0], ge};

	assign first       = index_q == 16'd0;
	assign with_common = !frag_q || first;
	assign flags = frag_q ? (frg_flag_q | (first ? com_flag_q : 8'd0)) : com_flag_q;
	assign ext   = frag_q ? (first ? EXT_FIRST : EXT_LATER) : EXT_SINGLE;

	always_comb begin
		if (frag_q && ({16'd0, lim_eff} < rem_q))
			chunk_n = {16'd0, lim_eff};
		else
			chunk_n = rem_q;
	end

	assign ts_off    = 4'd12 - pos_q[3:0];
	assign ts_sh     = ts_q >> {ts_off[2:0], 3'b000};
	assign abs_off   = 6'd35 - pos_q;
	assign abs_sh    = abs_q >> {abs_off[2:0], 3'b000};
	assign chunk_off = 2'(6'd17 - pos_q);
	assign chunk_sh  = chunk_q >> {chunk_off, 3'b000};
	assign media_off = 6'd38 - pos_q;
	assign media_sh  = media_q >> {media_off[1:0], 3'b000};

	always_comb begin
		case (pos_q) inside
			6'd0:            hdr_byte = magic_q[15:8];
			6'd1:            hdr_byte = magic_q[7:0];
			6'd2:            hdr_byte = version_q;
			6'd3:            hdr_byte = kind_q ? aud_type_q : vid_type_q;
			6'd4:            hdr_byte = flags;
			[6'd5:6'd12]:    hdr_byte = ts_sh[7:0];
			6'd13:           hdr_byte = ext;
			[6'd14:6'd17]:   hdr_byte = chunk_sh[7:0];
			6'd20:           hdr_byte = fnum_q[15:8];
			6'd21:           hdr_byte = fnum_q[7:0];
			6'd22:           hdr_byte = index_q[15:8];
			6'd23:           hdr_byte = index_q[7:0];
			6'd24:           hdr_byte = total_q[15:8];
			6'd25:           hdr_byte = total_q[7:0];
			6'd26:           hdr_byte = COMMON_TAG;
			6'd27:           hdr_byte = abs_flag_q;
			[6'd28:6'd35]:   hdr_byte = abs_sh[7:0];
			[6'd36:6'd38]:   hdr_byte = media_sh[7:0];
			default:         hdr_byte = 8'd0;
		endcase
	end

	always_comb begin
		if (pos_q == POS_FIXED_END)
			pos_n = frag_q ? POS_FRAG : POS_COMMON;
		else if (pos_q == POS_FRAG_END)
			pos_n = POS_COMMON;
		else
			pos_n = pos_q + 6'd1;
	end

	assign out_free = !out_valid_q || out_ready;
	assign load     = cmd.hdr_emit || cmd.pay_emit;

	// held message fields
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			data_q <= data_byte;
			if (message_start) begin
				ts_q      <= timestamp_ms;
				abs_q     <= abs_time_ms;
				kind_q    <= media_kind;
				fnum_q    <= frame_number;
				media_q   <= {codec_code, kind_detail, media_kind ? channel_count : 8'd0};
				num_q     <= numer;
				dr_q      <= 16'd0;
				div_lim_q <= lim_eff;
			end
		end else if (div_cnt_q != 6'd0) begin
			num_q <= num_n;
			dr_q  <= dr_n;
		end
		if (cmd.hdr_begin)
			chunk_q <= chunk_n;
		if (load) begin
			out_byte_q <= cmd.pay_emit ? data_q : hdr_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q     <= 16'd0;
			version_q   <= 8'd0;
			vid_type_q  <= 8'd0;
			aud_type_q  <= 8'd0;
			com_flag_q  <= 8'd0;
			frg_flag_q  <= 8'd0;
			abs_flag_q  <= 8'd1;
			frg_lim_q   <= 16'd1024;
			start_q     <= 1'b0;
			frag_q      <= 1'b0;
			rem_q       <= 32'd0;
			total_q     <= 16'd0;
			index_q     <= 16'd0;
			bif_q       <= 16'd0;
			pos_q       <= 6'd0;
			div_cnt_q   <= 6'd0;
			out_valid_q <= 1'b0;
			frame_end_q <= 1'b0;
			run_last_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_MAGIC:    magic_q    <= cfg_data;
					REG_VERSION:  version_q  <= cfg_data[7:0];
					REG_VID_TYPE: vid_type_q <= cfg_data[7:0];
					REG_AUD_TYPE: aud_type_q <= cfg_data[7:0];
					REG_COM_FLAG: com_flag_q <= cfg_data[7:0];
					REG_FRG_FLAG: frg_flag_q <= cfg_data[7:0];
					REG_ABS_FLAG: abs_flag_q <= cfg_data[7:0];
					REG_FRG_LIM:  frg_lim_q  <= cfg_data;
					default:      ;
				endcase
			end

			if (cmd.accept) begin
				start_q <= message_start;
				if (message_start) begin
					rem_q   <= message_length;
					frag_q  <= message_length > {16'd0, lim_eff};
					index_q <= 16'd0;
					bif_q   <= 16'd0;
					total_q <= 16'd1;
					div_cnt_q <= (message_length > {16'd0, lim_eff}) ? DIV_STEPS : 6'd0;
				end
			end else if (div_cnt_q != 6'd0) begin
				div_cnt_q <= div_cnt_q - 6'd1;
				if (div_cnt_q == 6'd1)
					total_q <= num_n[15:0];
			end

			if (cmd.hdr_begin) begin
				bif_q <= chunk_n[15:0];
				pos_q <= 6'd0;
			end else if (cmd.hdr_emit) begin
				pos_q <= pos_n;
			end
			if (cmd.hdr_done)
				index_q <= index_q + 16'd1;
			if (cmd.pay_emit) begin
				rem_q <= rem_q - 32'd1;
				bif_q <= bif_q - 16'd1;
			end else if (cmd.skip) begin
				rem_q <= rem_q - 32'd1;
			end

			if (load) begin
				out_valid_q <= 1'b1;
				frame_end_q <= cmd.pay_emit ? (bif_q == 16'd1) : cmd.hdr_flags;
				run_last_q  <= cmd.pay_emit ? 1'b1 : cmd.hdr_flags;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.div_busy   = div_cnt_q != 6'd0;
		sts.start      = start_q;
		sts.rem_zero   = rem_q == 32'd0;
		sts.bif_zero   = bif_q == 16'd0;
		sts.idx_ge_tot = index_q >= total_q;
		sts.hdr_last   = (pos_q == POS_FRAG_END && !with_common) || pos_q == POS_END;
		sts.out_free   = out_free;
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;
	assign run_last  = run_last_q;

endmodule

// File: rtl/core/mfp_ctrl.sv
// Controller state machine: sequences item intake, header bursts and payload bytes.
module mfp_ctrl import mfp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  mfp_sts_t sts,
	output mfp_cmd_t cmd
);

	logic [1:0] state_q, state_n;
	logic       zero_q, zero_n;

	always_comb begin
		state_n = state_q;
		zero_n  = zero_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid)
					state_n = ST_CHK;
			end
			ST_CHK: begin
				if (!sts.div_busy) begin
					if (sts.start && sts.rem_zero) begin
						// empty message: header-only frame
						cmd.hdr_begin = 1'b1;
						zero_n  = 1'b1;
						state_n = ST_HDR;
					end else if (sts.rem_zero) begin
						state_n = ST_IDLE;
					end else if (sts.bif_zero) begin
						if (sts.idx_ge_tot) begin
							cmd.skip = 1'b1;
							state_n  = ST_IDLE;
						end else begin
							cmd.hdr_begin = 1'b1;
							zero_n  = 1'b0;
							state_n = ST_HDR;
						end
					end else begin
						state_n = ST_PAY;
					end
				end
			end
			ST_HDR: begin
				if (sts.out_free) begin
					cmd.hdr_emit = 1'b1;
					if (sts.hdr_last) begin
						cmd.hdr_done  = 1'b1;
						cmd.hdr_flags = zero_q;
						state_n = zero_q ? ST_IDLE : ST_PAY;
					end
				end
			end
			ST_PAY: begin
				if (sts.out_free) begin
					cmd.pay_emit = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			zero_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			zero_q  <= zero_n;
		end
	end

	assign in_ready = state_q == ST_IDLE;

endmodule

// File: rtl/core/media_frame_packetizer.sv
// Media frame packetizer: byte-wide payload in, framed byte stream out.
// One item at a time. A payload item that needs no header passes through accept,
// check and emit; an item that opens a frame first emits its header (26, 34 or
// 40 bytes), one byte per cycle while the output is not stalled, through the
// single output register. A message start item whose length exceeds the fragment
// limit first passes through the bit-serial divider that computes the fragment count.
// cfg_ready is tied high; config writes are to be made only while the block is idle.
module media_frame_packetizer import mfp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               message_start,
	input  logic               media_kind,
	input  logic [7:0]         codec_code,
	input  logic [7:0]         kind_detail,
	input  logic [7:0]         channel_count,
	input  logic signed [63:0] timestamp_ms,
	input  logic signed [63:0] abs_time_ms,
	input  logic [15:0]        frame_number,
	input  logic [31:0]        message_length,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               frame_end,
	output logic               run_last
);

	mfp_cmd_t cmd;
	mfp_sts_t sts;

	assign cfg_ready = 1'b1;

	mfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mfp_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.data_byte     (data_byte),
		.message_start (message_start),
		.media_kind    (media_kind),
		.codec_code    (codec_code),
		.kind_detail   (kind_detail),
		.channel_count (channel_count),
		.timestamp_ms  (timestamp_ms),
		.abs_time_ms   (abs_time_ms),
		.frame_number  (frame_number),
		.message_length(message_length),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.frame_end     (frame_end),
		.run_last      (run_last)
	);

endmodule

// File: rtl/core/mfp_checker.sv
// Port-level checker for the packetizer and its bind.
module mfp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_ready,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       frame_end,
	input logic       run_last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(frame_end))
		else $error("result changed while stalled");

	// one item at a time: intake closes right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while another in flight");

	// a frame only ends on the last result of an item
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> run_last)
		else $error("frame end without run end");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");

endmodule

bind media_frame_packetizer mfp_checker u_mfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_ready (cfg_ready),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.frame_end (frame_end),
	.run_last  (run_last)
);
